>>> rtl/arep_pkg.sv
package arep_pkg;

    localparam int MAX_WIDTH_DEFAULT = 4096;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 13;
    localparam int DEPTH_W  = 5;
    localparam int ROW_W    = 13;

    localparam int MAX_RES     = 3;
    localparam int RES_IDX_W   = $clog2(MAX_RES);
    localparam int RES_CNT_W   = $clog2(MAX_RES + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_PIXEL_BITS = 1'b0;
    localparam logic REG_ROW_WIDTH  = 1'b1;

    localparam logic [1:0] KIND_LEFT    = 2'd0;
    localparam logic [1:0] KIND_RIGHT   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    typedef enum logic [5:0] {
        PH_LEAD   = 6'b000001,
        PH_LEFT   = 6'b000010,
        PH_OPAQUE = 6'b000100,
        PH_RIGHT  = 6'b001000,
        PH_TRAIL  = 6'b010000,
        PH_FAIL   = 6'b100000
    } arep_phase_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SAMPLE_W-1:0] delta;
        logic [COUNT_W-1:0]  zeros_left;
        logic [COUNT_W-1:0]  zeros_right;
        logic                row_fits;
        logic                last;
    } arep_res_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]        count;
        arep_res_t [MAX_RES-1:0]     item;
    } arep_push_t;

endpackage

>>> rtl/arep_core.sv
module arep_core #(
    parameter int MAX_WIDTH = arep_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic [arep_pkg::SAMPLE_W-1:0]  sample,
    input  logic [arep_pkg::DEPTH_W-1:0]   pixel_bits,
    input  logic [arep_pkg::ROW_W-1:0]     row_width,
    output arep_pkg::arep_push_t           push
);
    import arep_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int WW = (CW > ROW_W) ? CW : ROW_W;

    arep_phase_t         phase_reg, phase_next;
    logic [CW-1:0]       column_reg, column_next;
    logic [SAMPLE_W-1:0] prev_reg, prev_next;
    logic [SAMPLE_W-1:0] held_reg, held_next;
    logic                held_valid_reg, held_valid_next;
    logic [COUNT_W-1:0]  lead_reg, lead_next;
    logic [COUNT_W-1:0]  trail_reg, trail_next;

    logic [SAMPLE_W:0]   opaque;
    logic [WW-1:0]       width_eff;
    logic [WW-1:0]       col_inc;
    logic                row_end;
    logic [RES_CNT_W-1:0] res_count;
    arep_res_t [MAX_RES-1:0] res_item;

    function automatic logic below_opaque(input logic [SAMPLE_W-1:0] v,
                                          input logic [SAMPLE_W:0] op);
        return {1'b0, v} < op;
    endfunction

    function automatic arep_res_t mk_res(input logic [1:0] k,
                                         input logic [SAMPLE_W-1:0] d,
                                         input logic [COUNT_W-1:0] zl,
                                         input logic [COUNT_W-1:0] zr,
                                         input logic f,
                                         input logic l);
        arep_res_t r;
        r.kind        = k;
        r.delta       = d;
        r.zeros_left  = zl;
        r.zeros_right = zr;
        r.row_fits    = f;
        r.last        = l;
        return r;
    endfunction

    // depths above the sample width can never reach opaque
    always_comb
    begin
        if (pixel_bits > DEPTH_W'(SAMPLE_W))
            opaque = '1;
        else
            opaque = (SAMPLE_W+1)'(({{SAMPLE_W{1'b0}}, 1'b1} << pixel_bits) - 1'b1);
    end

    always_comb
    begin
        if (row_width == '0)
            width_eff = WW'(1);
        else if (WW'(row_width) > WW'(MAX_WIDTH))
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = WW'(row_width);
    end

    assign col_inc = WW'(column_reg) + WW'(1);
    assign row_end = col_inc >= width_eff;

    always_comb
    begin
        arep_phase_t          ph;
        logic [SAMPLE_W-1:0]  hs;
        logic                 hv;
        logic [COUNT_W-1:0]   lz;
        logic [COUNT_W-1:0]   tz;
        logic [RES_IDX_W:0]   n;
        logic                 done;

        ph   = phase_reg;
        hs   = held_reg;
        hv   = held_valid_reg;
        lz   = lead_reg;
        tz   = trail_reg;
        n    = '0;
        done = 1'b0;
        res_item = '0;

        // right border candidate against its successor
        if (hv)
        begin
            hv = 1'b0;
            if (hs > sample && below_opaque(hs, opaque))
            begin
                res_item[n[RES_IDX_W-1:0]] = mk_res(KIND_RIGHT, hs - sample, '0, '0,
                                                    1'b0, 1'b0);
                n = n + 1'b1;
            end
            else if (hs == '0)
            begin
                ph = PH_TRAIL;
                tz = tz + 1'b1;
            end
            else
            begin
                ph = PH_FAIL;
            end
            hs = '0;
        end

        if (ph == PH_LEAD)
        begin
            if (sample == '0)
            begin
                lz   = lz + 1'b1;
                done = 1'b1;
            end
            else
            begin
                ph = PH_LEFT;
            end
        end
        if (!done && ph == PH_LEFT)
        begin
            if (sample > prev_reg && below_opaque(sample, opaque))
            begin
                res_item[n[RES_IDX_W-1:0]] = mk_res(KIND_LEFT, sample - prev_reg, '0, '0,
                                                    1'b0, 1'b0);
                n    = n + 1'b1;
                done = 1'b1;
            end
            else
            begin
                ph = PH_OPAQUE;
            end
        end
        if (!done && ph == PH_OPAQUE)
        begin
            if ({1'b0, sample} == opaque)
                done = 1'b1;
            else
                ph = PH_RIGHT;
        end
        if (!done && ph == PH_RIGHT)
        begin
            hs   = sample;
            hv   = 1'b1;
            done = 1'b1;
        end
        if (!done && ph == PH_TRAIL)
        begin
            if (sample == '0)
                tz = tz + 1'b1;
            else
                ph = PH_FAIL;
        end

        phase_next      = ph;
        held_next       = hs;
        held_valid_next = hv;
        lead_next       = lz;
        trail_next      = tz;
        prev_next       = sample;
        column_next     = col_inc[CW-1:0];

        // row end: close the pending candidate against zero, then summary
        if (row_end)
        begin
            if (hv)
            begin
                if (hs != '0 && below_opaque(hs, opaque))
                begin
                    res_item[n[RES_IDX_W-1:0]] = mk_res(KIND_RIGHT, hs, '0, '0,
                                                        1'b0, 1'b0);
                    n = n + 1'b1;
                end
                else if (hs == '0)
                begin
                    ph = PH_TRAIL;
                    tz = tz + 1'b1;
                end
                else
                begin
                    ph = PH_FAIL;
                end
            end
            res_item[n[RES_IDX_W-1:0]] = mk_res(KIND_SUMMARY, '0, lz, tz,
                                                ph != PH_FAIL, 1'b1);
            n = n + 1'b1;

            phase_next      = PH_LEAD;
            held_next       = '0;
            held_valid_next = 1'b0;
            lead_next       = '0;
            trail_next      = '0;
            prev_next       = '0;
            column_next     = '0;
        end

        res_count = RES_CNT_W'(n);
    end

    assign push.count = fire ? res_count : '0;
    assign push.item  = res_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEAD;
            column_reg     <= '0;
            prev_reg       <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            lead_reg       <= '0;
            trail_reg      <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            column_reg     <= column_next;
            prev_reg       <= prev_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            lead_reg       <= lead_next;
            trail_reg      <= trail_next;
        end
    end

    a_held_in_right: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> phase_reg == PH_RIGHT)
        else $error("held sample outside right border phase");

    a_three_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_count == RES_CNT_W'(MAX_RES)) |-> row_end)
        else $error("three results without row end");

    a_row_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && row_end) |=> (column_reg == '0 && !held_valid_reg
                               && phase_reg == PH_LEAD))
        else $error("row state not cleared after summary");

endmodule

>>> rtl/arep_queue.sv
module arep_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  arep_pkg::arep_push_t push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_stall,
    output arep_pkg::arep_res_t  out_item
);
    import arep_pkg::*;

    arep_res_t          q_reg  [QUEUE_DEPTH];
    arep_res_t          q_next [QUEUE_DEPTH];
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic [QCNT_W-1:0]  base;
    logic               pop;

    assign out_valid = count_reg != '0;
    assign out_item  = q_reg[0];
    assign pop       = out_valid && !out_stall;
    assign room      = count_reg <= QCNT_W'(QUEUE_DEPTH - MAX_RES);
    assign base      = count_reg - QCNT_W'(pop);

    always_comb
    begin
        logic [QCNT_W-1:0] off;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && i != QUEUE_DEPTH - 1)
                q_next[i] = q_reg[(i + 1) % QUEUE_DEPTH];
            else
                q_next[i] = q_reg[i];
            off = QCNT_W'(i) - base;
            if (QCNT_W'(i) >= base && off < QCNT_W'(push.count))
                q_next[i] = push.item[off[RES_IDX_W-1:0]];
        end
        count_next = base + QCNT_W'(push.count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            q_reg[i] <= q_next[i];
    end

endmodule

>>> rtl/alpha_row_edge_profiler_unit.sv
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_stall  | sample
// out      | out_valid / out_stall| kind, delta, zeros_left, zeros_right,
//          |                      | row_fits, last
// cfg      | apb psel / penable   | paddr, pwdata, prdata (pixel_bits, row_width)
//
// one sample per cycle; a sample is processed while it sits in the input register
// and its results enter a four-entry output queue at the next edge
// a sample is processed only while the queue has room for three results, so only
// a row end (up to three results) or a stalled output slows the input
// reset clears the row state and sets pixel_bits to 8 and row_width to 1024
module alpha_row_edge_profiler_unit #(
    parameter int MAX_WIDTH = arep_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [arep_pkg::PADDR_W-1:0]   paddr,
    input  logic [arep_pkg::PDATA_W-1:0]   pwdata,
    output logic [arep_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [arep_pkg::SAMPLE_W-1:0]  sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     kind,
    output logic [arep_pkg::SAMPLE_W-1:0]  delta,
    output logic [arep_pkg::COUNT_W-1:0]   zeros_left,
    output logic [arep_pkg::COUNT_W-1:0]   zeros_right,
    output logic                           row_fits,
    output logic                           last
);
    import arep_pkg::*;

    logic [DEPTH_W-1:0]  pixel_bits_reg;
    logic [ROW_W-1:0]    row_width_reg;
    logic                reg_index;
    logic                cfg_write;

    logic                in_full_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                in_take;
    logic                fire;
    logic                room;

    arep_push_t          push;
    arep_res_t           out_item;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_bits_reg <= DEPTH_W'(8);
            row_width_reg  <= ROW_W'(1024);
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_PIXEL_BITS: pixel_bits_reg <= pwdata[DEPTH_W-1:0];
                REG_ROW_WIDTH:  row_width_reg  <= pwdata[ROW_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_PIXEL_BITS: prdata = PDATA_W'(pixel_bits_reg);
            REG_ROW_WIDTH:  prdata = PDATA_W'(row_width_reg);
            default:        prdata = '0;
        endcase
    end

    // input register, refilled in the cycle it is drained
    assign fire     = in_full_reg && room;
    assign in_stall = in_full_reg && !room;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (in_take)
            in_full_reg <= 1'b1;
        else if (fire)
            in_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            sample_reg <= sample;
    end

    arep_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .sample     (sample_reg),
        .pixel_bits (pixel_bits_reg),
        .row_width  (row_width_reg),
        .push       (push)
    );

    arep_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    assign kind        = out_item.kind;
    assign delta       = out_item.delta;
    assign zeros_left  = out_item.zeros_left;
    assign zeros_right = out_item.zeros_right;
    assign row_fits    = out_item.row_fits;
    assign last        = out_item.last;

endmodule
